@@ rtl/core/compacting_record_table_search_core_macros.svh @@
// ----------------------------------------------------------------------------
// compacting record table search core: assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef COMPACTING_RECORD_TABLE_SEARCH_CORE_MACROS_SVH
`define COMPACTING_RECORD_TABLE_SEARCH_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CRTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crts same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define CRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crts next-cycle check failed");

`endif

@@ rtl/core/crts_pkg.sv @@
// ----------------------------------------------------------------------------
// crts_pkg
// types, codes and the name compare shared by the record table search core
// ----------------------------------------------------------------------------
package crts_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 7;
    localparam int INPOS_W      = 8;

    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_SEARCH  = 2'd2;
    localparam logic [1:0] ACT_DISPLAY = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADIDX   = 3'd3;
    localparam logic [2:0] ST_REC      = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    typedef struct packed {
        logic [63:0] name_head;
        logic [7:0]  name_tail;
        logic [63:0] surname_head;
        logic [7:0]  surname_tail;
        logic [63:0] phone_head;
        logic [7:0]  phone_tail;
    } t_rec;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic               rotate;
        logic               remove;
        logic               add;
        logic [INPOS_W-1:0] pos;
    } t_cell_ctl;

    // string compare that stops at the first zero byte of the stored name
    function automatic logic names_equal(input logic [63:0] a_head, input logic [7:0] a_tail,
                                         input logic [63:0] b_head, input logic [7:0] b_tail);
        logic       eq;
        logic       stop;
        logic [7:0] a;
        logic [7:0] b;
        eq   = 1'b1;
        stop = 1'b0;
        for (int j = 0; j < 9; j++) begin
            if (j < 8) begin
                a = a_head[63-8*j -: 8];
                b = b_head[63-8*j -: 8];
            end else begin
                a = a_tail;
                b = b_tail;
            end
            if (!stop) begin
                if (a != b) begin
                    eq   = 1'b0;
                    stop = 1'b1;
                end else if (a == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
        return eq;
    endfunction

endpackage

@@ rtl/core/crts_cell.sv @@
// ----------------------------------------------------------------------------
// crts_cell
// one table slot: loads a new record, takes its right neighbor on a shift
// ----------------------------------------------------------------------------
module crts_cell #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                 i_clk,
    input  crts_pkg::t_cell_ctl  i_ctl,
    input  logic [CNT_W-1:0]     i_cnt,
    input  crts_pkg::t_rec       i_load,
    input  crts_pkg::t_rec       i_nb,
    output crts_pkg::t_rec       o_rec
);
    import crts_pkg::*;

    localparam logic [CNT_W-1:0]   MY_IDX = CNT_W'(IDX);
    localparam logic [INPOS_W-1:0] SLOT   = INPOS_W'(IDX + 1);

    t_rec r_rec;

    // remove closes the gap: slots at or after the deleted one pull from the right
    always_ff @(posedge i_clk) begin
        if (i_ctl.add && (i_cnt == MY_IDX)) begin
            r_rec <= i_load;
        end else if (i_ctl.rotate || (i_ctl.remove && (SLOT >= i_ctl.pos))) begin
            r_rec <= i_nb;
        end
    end

    assign o_rec = r_rec;

endmodule

@@ rtl/core/compacting_record_table_search_core.sv @@
// ----------------------------------------------------------------------------
// compacting_record_table_search_core
// packed record table in a ring of cells with add, remove, search and display
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// command   in         start & !busy             i_action, i_position, record fields
// result    out        o_strobe, one cycle each  o_status, o_record_position,
//                                                record fields, o_last
//
// add and remove never raise busy; the single result beat follows in the next cycle.
// display of a non-empty table and search hold busy while the ring of cells
// rotates once past cell 0, one record per cycle, back to its original order.
// synchronous reset clears the count and control; record cells are not cleared.
// results cannot be stalled by the receiver.
module compacting_record_table_search_core #(
    parameter int CAPACITY = crts_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic [crts_pkg::INPOS_W-1:0] i_position,
    input  logic [63:0]                 i_name_head,
    input  logic [7:0]                  i_name_tail,
    input  logic [63:0]                 i_surname_head,
    input  logic [7:0]                  i_surname_tail,
    input  logic [63:0]                 i_phone_head,
    input  logic [7:0]                  i_phone_tail,
    output logic                        o_strobe,
    output logic [2:0]                  o_status,
    output logic [crts_pkg::POS_W-1:0]  o_record_position,
    output logic [63:0]                 o_out_name_head,
    output logic [7:0]                  o_out_name_tail,
    output logic [63:0]                 o_out_surname_head,
    output logic [7:0]                  o_out_surname_tail,
    output logic [63:0]                 o_out_phone_head,
    output logic [7:0]                  o_out_phone_tail,
    output logic                        o_last
);
    import crts_pkg::*;

    localparam int              CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LAST_I = CNT_W'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_search, n_search;
    logic [63:0]      r_key_head, n_key_head;
    logic [7:0]       r_key_tail, n_key_tail;
    logic             r_pend, n_pend;
    t_rec             r_pend_rec, n_pend_rec;
    logic [POS_W-1:0] r_pend_pos, n_pend_pos;

    logic             r_strobe, n_strobe;
    logic [2:0]       r_status, n_status;
    logic [POS_W-1:0] r_pos, n_pos;
    t_rec             r_orec, n_orec;
    logic             r_last, n_last;

    t_cell_ctl        w_ctl;
    t_rec             w_load;
    t_rec             w_rec [CAPACITY];
    logic             w_accept;
    logic             w_live;
    logic             w_match;
    logic [POS_W-1:0] w_cur_pos;

    assign w_load = '{name_head: i_name_head, name_tail: i_name_tail,
                      surname_head: i_surname_head, surname_tail: i_surname_tail,
                      phone_head: i_phone_head, phone_tail: i_phone_tail};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_rec w_nb;
        if (i == CAPACITY - 1) begin : g_wrap
            assign w_nb = w_rec[0];
        end else begin : g_link
            assign w_nb = w_rec[i+1];
        end
        crts_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_cnt  (r_cnt),
            .i_load (w_load),
            .i_nb   (w_nb),
            .o_rec  (w_rec[i])
        );
    end

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && (r_state == S_IDLE);
    assign w_live    = (r_idx < r_cnt);
    assign w_match   = names_equal(w_rec[0].name_head, w_rec[0].name_tail,
                                   r_key_head, r_key_tail);
    assign w_cur_pos = POS_W'(r_idx) + POS_W'(1);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_search   = r_search;
        n_key_head = r_key_head;
        n_key_tail = r_key_tail;
        n_pend     = r_pend;
        n_pend_rec = r_pend_rec;
        n_pend_pos = r_pend_pos;
        n_strobe   = 1'b0;
        n_status   = ST_DONE;
        n_pos      = '0;
        n_orec     = '0;
        n_last     = 1'b1;
        w_ctl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        ACT_ADD: begin
                            n_strobe = 1'b1;
                            if (r_cnt == CAP_C) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.add = 1'b1;
                                n_cnt     = r_cnt + CNT_W'(1);
                            end
                        end
                        ACT_REMOVE: begin
                            n_strobe = 1'b1;
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else if ((i_position == '0) ||
                                         (i_position > INPOS_W'(r_cnt))) begin
                                n_status = ST_BADIDX;
                            end else begin
                                w_ctl.remove = 1'b1;
                                w_ctl.pos    = i_position;
                                n_cnt        = r_cnt - CNT_W'(1);
                            end
                        end
                        ACT_SEARCH: begin
                            n_state    = S_WALK;
                            n_search   = 1'b1;
                            n_key_head = i_name_head;
                            n_key_tail = i_name_tail;
                            n_idx      = '0;
                            n_pend     = 1'b0;
                        end
                        ACT_DISPLAY: begin
                            if (r_cnt != '0) begin
                                n_state  = S_WALK;
                                n_search = 1'b0;
                                n_idx    = '0;
                                n_pend   = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                w_ctl.rotate = 1'b1;
                n_idx        = r_idx + CNT_W'(1);
                if (r_idx == LAST_I) begin
                    n_state = r_search ? S_FIN : S_IDLE;
                end
                if (w_live) begin
                    if (!r_search) begin
                        n_strobe = 1'b1;
                        n_status = ST_REC;
                        n_pos    = w_cur_pos;
                        n_orec   = w_rec[0];
                        n_last   = ((r_idx + CNT_W'(1)) == r_cnt);
                    end else if (w_match) begin
                        // hold each match back until the next one so the final one can carry last
                        if (r_pend) begin
                            n_strobe = 1'b1;
                            n_status = ST_REC;
                            n_pos    = r_pend_pos;
                            n_orec   = r_pend_rec;
                            n_last   = 1'b0;
                        end
                        n_pend     = 1'b1;
                        n_pend_rec = w_rec[0];
                        n_pend_pos = w_cur_pos;
                    end
                end
            end
            S_FIN: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                if (r_pend) begin
                    n_status = ST_REC;
                    n_pos    = r_pend_pos;
                    n_orec   = r_pend_rec;
                end else begin
                    n_status = ST_NOTFOUND;
                end
                n_pend = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_search <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_search <= n_search;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_head <= n_key_head;
        r_key_tail <= n_key_tail;
        r_pend_rec <= n_pend_rec;
        r_pend_pos <= n_pend_pos;
        r_status   <= n_status;
        r_pos      <= n_pos;
        r_orec     <= n_orec;
        r_last     <= n_last;
    end

    assign o_strobe           = r_strobe;
    assign o_status           = r_status;
    assign o_record_position  = r_pos;
    assign o_out_name_head    = r_orec.name_head;
    assign o_out_name_tail    = r_orec.name_tail;
    assign o_out_surname_head = r_orec.surname_head;
    assign o_out_surname_tail = r_orec.surname_tail;
    assign o_out_phone_head   = r_orec.phone_head;
    assign o_out_phone_tail   = r_orec.phone_tail;
    assign o_last             = r_last;

endmodule

@@ rtl/core/crts_checker.sv @@
// ----------------------------------------------------------------------------
// crts_checker
// port-level checks on result beats of the record table search core
// ----------------------------------------------------------------------------
`include "compacting_record_table_search_core_macros.svh"

module crts_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   i_action,
    input logic                         o_strobe,
    input logic [2:0]                   o_status,
    input logic [crts_pkg::POS_W-1:0]   o_record_position,
    input logic                         o_last
);
    import crts_pkg::*;

    logic w_take;
    logic w_edit;
    logic w_rec_beat;
    logic w_flag_beat;

    assign w_take      = start && !busy;
    assign w_edit      = (i_action == ACT_ADD) || (i_action == ACT_REMOVE);
    assign w_rec_beat  = o_strobe && (o_status == ST_REC);
    assign w_flag_beat = o_strobe && (o_status != ST_REC);

    // status-only beats always close their command
    `CRTS_ASSERT_NOW(a_status_last, i_clk, i_rst_n, w_flag_beat, o_last)

    // only record beats carry a position, and theirs is never zero
    `CRTS_ASSERT_NOW(a_pos_zero, i_clk, i_rst_n, w_flag_beat, o_record_position == '0)
    `CRTS_ASSERT_NOW(a_pos_set, i_clk, i_rst_n, w_rec_beat, o_record_position != '0)

    // add and remove answer with exactly one beat in the following cycle
    `CRTS_ASSERT_NEXT(a_edit_reply, i_clk, i_rst_n, w_take && w_edit, o_strobe && o_last)

    // a search always walks the table
    `CRTS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, w_take && (i_action == ACT_SEARCH), busy)

endmodule

bind compacting_record_table_search_core crts_checker u_crts_checker (.*);

@@ test/tb_compacting_record_table_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compacting_record_table_search_core
// drives add, remove, search and display commands into the record table core;
// a scoreboard keeps its own copy of the table and checks every result beat
// ----------------------------------------------------------------------------
module tb_compacting_record_table_search_core;
    import crts_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int NUM_ITEMS   = 370;
    localparam int POOL_SIZE   = 6;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = CAP + 16;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] position;
        t_rec       rec;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] rec_pos;
        t_rec       rec;
        logic       last;
    } t_beat;

    typedef enum {PH_FILL, PH_DRAIN, PH_CHURN} t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [7:0]  i_position;
    logic [63:0] i_name_head;
    logic [7:0]  i_name_tail;
    logic [63:0] i_surname_head;
    logic [7:0]  i_surname_tail;
    logic [63:0] i_phone_head;
    logic [7:0]  i_phone_tail;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [6:0]  o_record_position;
    logic [63:0] o_out_name_head;
    logic [7:0]  o_out_name_tail;
    logic [63:0] o_out_surname_head;
    logic [7:0]  o_out_surname_tail;
    logic [63:0] o_out_phone_head;
    logic [7:0]  o_out_phone_tail;
    logic        o_last;

    t_cmd        cmd_q[$];
    t_beat       expected_beats[$];
    t_rec        rows[CAP];
    int          row_count;
    logic [71:0] name_pool[POOL_SIZE];
    int          pool_len[POOL_SIZE];
    int          gen_count;
    int          fail_count;
    int          gap_left;
    int          calm_left;
    int          stall_cycles;
    logic        took_beat;

    compacting_record_table_search_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_position         (i_position),
        .i_name_head        (i_name_head),
        .i_name_tail        (i_name_tail),
        .i_surname_head     (i_surname_head),
        .i_surname_tail     (i_surname_tail),
        .i_phone_head       (i_phone_head),
        .i_phone_tail       (i_phone_tail),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_record_position  (o_record_position),
        .o_out_name_head    (o_out_name_head),
        .o_out_name_tail    (o_out_name_tail),
        .o_out_surname_head (o_out_surname_head),
        .o_out_surname_tail (o_out_surname_tail),
        .o_out_phone_head   (o_out_phone_head),
        .o_out_phone_tail   (o_out_phone_tail),
        .o_last             (o_last)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // string helpers: 9 bytes as {head, tail}, first byte on top
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [71:0] rand72();
        logic [71:0] v;
        v[71:40] = $urandom;
        v[39:8]  = $urandom;
        v[7:0]   = rand_byte();
        return v;
    endfunction

    // len nonzero bytes, a zero terminator, then optional junk
    function automatic logic [71:0] make_str(int len, bit junk);
        logic [71:0] s;
        s = '0;
        for (int j = 0; j < 9; j++) begin
            if (j < len)
                s[71-8*j -: 8] = 8'($urandom_range(1, 255));
            else if (junk && j > len)
                s[71-8*j -: 8] = rand_byte();
        end
        return s;
    endfunction

    function automatic bit same_name(logic [71:0] a, logic [71:0] b);
        for (int j = 0; j < 9; j++) begin
            if (a[71-8*j -: 8] != b[71-8*j -: 8])
                return 1'b0;
            if (a[71-8*j -: 8] == 8'd0)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    // pool name with fresh junk after its terminator
    function automatic logic [71:0] pool_key(int k);
        logic [71:0] s;
        s = name_pool[k];
        for (int j = pool_len[k] + 1; j < 9; j++)
            if ($urandom_range(0, 1))
                s[71-8*j -: 8] = rand_byte();
        return s;
    endfunction

    function automatic t_rec rand_rec();
        t_rec        r;
        logic [71:0] n;
        int          k;
        k = $urandom_range(0, 9);
        if (k < 5)
            n = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (k < 7)
            n = pool_key($urandom_range(0, POOL_SIZE - 1));
        else if (k < 9)
            n = make_str($urandom_range(0, 9), 1'($urandom_range(0, 1)));
        else
            n = rand72();
        {r.name_head, r.name_tail} = n;
        if ($urandom_range(0, 1))
            {r.surname_head, r.surname_tail} = rand72();
        else
            {r.surname_head, r.surname_tail} = make_str($urandom_range(0, 9), 1'b0);
        if ($urandom_range(0, 1))
            {r.phone_head, r.phone_tail} = rand72();
        else
            {r.phone_head, r.phone_tail} = make_str($urandom_range(0, 9), 1'b0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus queue; gen_count tracks the fill level to steer the mix
    // ------------------------------------------------------------------
    task automatic push_cmd(logic [1:0] act, logic [7:0] pos, t_rec r);
        t_cmd c;
        c.action   = act;
        c.position = pos;
        c.rec      = r;
        cmd_q.push_back(c);
        if (act == ACT_ADD && gen_count < CAP)
            gen_count++;
        else if (act == ACT_REMOVE && gen_count > 0 && pos >= 1 && pos <= gen_count)
            gen_count--;
    endtask

    function automatic logic [7:0] pick_pos(int valid_pct);
        int r;
        r = $urandom_range(0, 99);
        if (gen_count > 0 && r < valid_pct)
            return 8'($urandom_range(1, gen_count));
        if (r % 3 == 0)
            return 8'd0;
        if (r % 3 == 1)
            return 8'(gen_count + 1);
        return rand_byte();
    endfunction

    task automatic push_search(logic [71:0] key);
        t_rec r;
        r = rand_rec();
        {r.name_head, r.name_tail} = key;
        push_cmd(ACT_SEARCH, rand_byte(), r);
    endtask

    task automatic push_add_named(logic [71:0] n);
        t_rec r;
        r = rand_rec();
        {r.name_head, r.name_tail} = n;
        push_cmd(ACT_ADD, rand_byte(), r);
    endtask

    task automatic push_random(t_phase ph);
        int w;
        w = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                if (w < 75)      push_cmd(ACT_ADD, rand_byte(), rand_rec());
                else if (w < 85) push_search(pool_key($urandom_range(0, POOL_SIZE - 1)));
                else if (w < 90) push_cmd(ACT_DISPLAY, rand_byte(), rand_rec());
                else             push_cmd(ACT_REMOVE, pick_pos(70), rand_rec());
            end
            PH_DRAIN: begin
                if (w < 70)      push_cmd(ACT_REMOVE, pick_pos(92), rand_rec());
                else if (w < 78) push_cmd(ACT_ADD, rand_byte(), rand_rec());
                else if (w < 92) push_search(pool_key($urandom_range(0, POOL_SIZE - 1)));
                else             push_cmd(ACT_DISPLAY, rand_byte(), rand_rec());
            end
            default: begin
                if (w < 40)      push_cmd(ACT_ADD, rand_byte(), rand_rec());
                else if (w < 65) push_cmd(ACT_REMOVE, pick_pos(75), rand_rec());
                else if (w < 80) push_search(pool_key($urandom_range(0, POOL_SIZE - 1)));
                else if (w < 87) push_search($urandom_range(0, 1) ?
                                             make_str(9, 1'b0) : rand72());
                else             push_cmd(ACT_DISPLAY, rand_byte(), rand_rec());
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------
    task automatic expect_beat(logic [2:0] st, int idx, bit last);
        t_beat e;
        e        = '0;
        e.status = st;
        e.last   = last;
        if (idx >= 0) begin
            e.rec_pos = 7'(idx + 1);
            e.rec     = rows[idx];
        end
        expected_beats.push_back(e);
    endtask

    task automatic predict_cmd(t_cmd c);
        logic [71:0] key;
        int          final_hit;
        key       = {c.rec.name_head, c.rec.name_tail};
        final_hit = -1;
        case (c.action)
            ACT_ADD: begin
                if (row_count >= CAP) begin
                    expect_beat(ST_FULL, -1, 1'b1);
                end else begin
                    rows[row_count] = c.rec;
                    row_count++;
                    expect_beat(ST_DONE, -1, 1'b1);
                end
            end
            ACT_REMOVE: begin
                if (row_count == 0) begin
                    expect_beat(ST_EMPTY, -1, 1'b1);
                end else if (c.position == 0 || c.position > row_count) begin
                    expect_beat(ST_BADIDX, -1, 1'b1);
                end else begin
                    for (int i = c.position - 1; i < row_count - 1; i++)
                        rows[i] = rows[i + 1];
                    row_count--;
                    expect_beat(ST_DONE, -1, 1'b1);
                end
            end
            ACT_SEARCH: begin
                for (int i = 0; i < row_count; i++)
                    if (same_name({rows[i].name_head, rows[i].name_tail}, key))
                        final_hit = i;
                if (final_hit < 0)
                    expect_beat(ST_NOTFOUND, -1, 1'b1);
                for (int i = 0; i <= final_hit; i++)
                    if (same_name({rows[i].name_head, rows[i].name_tail}, key))
                        expect_beat(ST_REC, i, i == final_hit);
            end
            default: begin
                // empty table lists nothing at all
                for (int i = 0; i < row_count; i++)
                    expect_beat(ST_REC, i, i == row_count - 1);
            end
        endcase
    endtask

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", fname, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: new values at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_cmd nxt;
        if (i_rst_n) begin
            if (!start || took_beat) begin
                if (gap_left > 0) begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (cmd_q.size() > 0) begin
                    nxt            = cmd_q.pop_front();
                    i_action       <= nxt.action;
                    i_position     <= nxt.position;
                    i_name_head    <= nxt.rec.name_head;
                    i_name_tail    <= nxt.rec.name_tail;
                    i_surname_head <= nxt.rec.surname_head;
                    i_surname_tail <= nxt.rec.surname_tail;
                    i_phone_head   <= nxt.rec.phone_head;
                    i_phone_tail   <= nxt.rec.phone_tail;
                    start          <= 1'b1;
                    // occasional back-to-back stretch
                    if (calm_left > 0) begin
                        calm_left <= calm_left - 1;
                        gap_left  <= 0;
                    end else begin
                        if ($urandom_range(0, 24) == 0)
                            calm_left <= $urandom_range(8, 24);
                        gap_left <= $urandom_range(0, 12);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: results checked before the command taken at the same edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_cmd  seen;
        t_beat want;
        took_beat <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: status %0d pos %0d",
                           o_status, o_record_position);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("status", 64'(want.status), 64'(o_status));
                    check_field("record_position", 64'(want.rec_pos),
                                64'(o_record_position));
                    check_field("out_name_head", want.rec.name_head, o_out_name_head);
                    check_field("out_name_tail", 64'(want.rec.name_tail),
                                64'(o_out_name_tail));
                    check_field("out_surname_head", want.rec.surname_head,
                                o_out_surname_head);
                    check_field("out_surname_tail", 64'(want.rec.surname_tail),
                                64'(o_out_surname_tail));
                    check_field("out_phone_head", want.rec.phone_head, o_out_phone_head);
                    check_field("out_phone_tail", 64'(want.rec.phone_tail),
                                64'(o_out_phone_tail));
                    check_field("last", 64'(want.last), 64'(o_last));
                end
            end
            if (start && !busy) begin
                seen.action           = i_action;
                seen.position         = i_position;
                seen.rec.name_head    = i_name_head;
                seen.rec.name_tail    = i_name_tail;
                seen.rec.surname_head = i_surname_head;
                seen.rec.surname_tail = i_surname_tail;
                seen.rec.phone_head   = i_phone_head;
                seen.rec.phone_tail   = i_phone_tail;
                predict_cmd(seen);
            end
        end
    end

    // watchdog on cycles with neither a command nor a result taken
    always @(posedge i_clk) begin : watchdog
        if ((start && !busy) || o_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : run
        t_phase ph;
        t_rec   r;
        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_action       = ACT_ADD;
        i_position     = '0;
        i_name_head    = '0;
        i_name_tail    = '0;
        i_surname_head = '0;
        i_surname_tail = '0;
        i_phone_head   = '0;
        i_phone_tail   = '0;
        row_count      = 0;
        gen_count      = 0;
        fail_count     = 0;
        gap_left       = 0;
        calm_left      = 0;
        stall_cycles   = 0;
        took_beat      = 1'b0;

        // full-length and empty names plus a few short ones
        pool_len[0] = 9;
        pool_len[1] = 0;
        for (int k = 2; k < POOL_SIZE; k++)
            pool_len[k] = $urandom_range(1, 8);
        for (int k = 0; k < POOL_SIZE; k++)
            name_pool[k] = make_str(pool_len[k], 1'b0);

        // empty table: display says nothing, search misses, remove reports empty
        push_cmd(ACT_DISPLAY, 8'd0, rand_rec());
        push_search(name_pool[2]);
        push_cmd(ACT_REMOVE, 8'd1, rand_rec());
        push_cmd(ACT_REMOVE, 8'd0, rand_rec());
        push_cmd(ACT_REMOVE, 8'd255, rand_rec());
        r = '1;
        push_cmd(ACT_ADD, 8'd255, r);
        r = '0;
        push_cmd(ACT_ADD, 8'd0, r);
        push_add_named(name_pool[0]);
        // stored junk after the terminator must come back untouched
        push_add_named(pool_key(2));
        push_add_named(name_pool[2]);
        push_search(72'd0);
        push_search(pool_key(2));
        push_search({72{1'b1}});
        push_search(pool_key(0));
        push_search(make_str(9, 1'b0));
        push_cmd(ACT_REMOVE, 8'd0, rand_rec());
        push_cmd(ACT_REMOVE, 8'(gen_count + 1), rand_rec());
        push_cmd(ACT_REMOVE, 8'd255, rand_rec());
        push_cmd(ACT_DISPLAY, 8'd255, rand_rec());
        push_cmd(ACT_REMOVE, 8'd1, rand_rec());
        push_cmd(ACT_REMOVE, 8'(gen_count), rand_rec());
        push_cmd(ACT_REMOVE, 8'd2, rand_rec());
        push_cmd(ACT_DISPLAY, 8'd0, rand_rec());
        push_search(pool_key(2));

        // fill to capacity, hit the full case, drain to empty, then churn
        ph = PH_FILL;
        while (cmd_q.size() < NUM_ITEMS) begin
            push_random(ph);
            if (ph == PH_FILL && gen_count == CAP) begin
                push_cmd(ACT_ADD, rand_byte(), rand_rec());
                push_cmd(ACT_DISPLAY, rand_byte(), rand_rec());
                push_search(pool_key($urandom_range(0, POOL_SIZE - 1)));
                push_cmd(ACT_ADD, rand_byte(), rand_rec());
                push_cmd(ACT_REMOVE, 8'(CAP), rand_rec());
                push_cmd(ACT_REMOVE, 8'(CAP + 1), rand_rec());
                ph = PH_DRAIN;
            end else if (ph == PH_DRAIN && gen_count == 0) begin
                push_cmd(ACT_REMOVE, rand_byte(), rand_rec());
                push_cmd(ACT_DISPLAY, rand_byte(), rand_rec());
                ph = PH_CHURN;
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start)
            @(posedge i_clk);
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ compacting_record_table_search_core.f @@
+incdir+rtl/core
rtl/core/crts_pkg.sv
rtl/core/crts_cell.sv
rtl/core/compacting_record_table_search_core.sv
rtl/core/crts_checker.sv
test/tb_compacting_record_table_search_core.sv
